### sv/wpe_pkg.sv
// Shared types, constants and register indexes for the waveform peak envelope decimator.
package wpe_pkg;

   localparam int MAX_CHANNELS = 8;
   localparam int SAMPLE_BITS  = 16;
   localparam int NUM_LEVELS   = 2;
   localparam int CH_BITS      = 3;
   localparam int LEN_BITS     = 17;
   localparam int CC_BITS      = 4;
   localparam int SUM_BITS     = 32;
   localparam int MAG_BITS     = SAMPLE_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_BITS     = 17;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CHANNEL_COUNT    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_LEN_FINE   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCK_LEN_COARSE = 2'd2;

   localparam logic [CC_BITS-1:0]  CHANNEL_COUNT_RESET    = 4'd2;
   localparam logic [LEN_BITS-1:0] BLOCK_LEN_FINE_RESET   = 17'd256;
   localparam logic [LEN_BITS-1:0] BLOCK_LEN_COARSE_RESET = 17'd362;
   localparam logic [LEN_BITS-1:0] FRAMES_MAX             = '1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   typedef struct packed {
      logic                          op;
      logic signed [SAMPLE_BITS-1:0] sample;
   } req_type;

   typedef struct packed {
      logic                          level;
      logic [CH_BITS-1:0]            chan;
      logic signed [SAMPLE_BITS-1:0] min_value;
      logic signed [SAMPLE_BITS-1:0] max_value;
      logic [SAMPLE_BITS-1:0]        abs_mean;
      logic                          last;
   } rsp_type;

   typedef struct packed {
      logic                          upd;
      logic [CH_BITS-1:0]            ch;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [NUM_LEVELS-1:0]         first;
      logic [NUM_LEVELS-1:0]         clear;
      logic [CH_BITS-1:0]            rd_ch;
      logic                          rd_lv;
   } acc_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPLY,
      ST_SCAN,
      ST_START,
      ST_DIV,
      ST_OUT
   } state_type;

endpackage

### sv/wpe_divider.sv
// Restoring divider, one quotient bit per cycle, shared by every record's mean.
module wpe_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [wpe_pkg::SUM_BITS-1:0]  dividend,
   input  logic [wpe_pkg::LEN_BITS-1:0]  divisor,
   output logic                          done,
   output logic [wpe_pkg::SUM_BITS-1:0]  quotient
);
   import wpe_pkg::*;

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [SUM_BITS-1:0]     quo_ff, quo_in;
   logic [LEN_BITS-1:0]     rem_ff, rem_in;
   logic [LEN_BITS-1:0]     div_ff, div_in;
   logic [LEN_BITS:0]       trial;
   logic                    ge;

   assign trial = {rem_ff, quo_ff[SUM_BITS-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (run_ff) begin
         quo_in = {quo_ff[SUM_BITS-2:0], ge};
         rem_in = ge ? LEN_BITS'(trial - {1'b0, div_ff}) : trial[LEN_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(SUM_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### sv/wpe_accum.sv
// Per channel and level min, max and absolute-sum stores with level clear.
module wpe_accum (
   input  logic                                 clock,
   input  logic                                 reset,
   input  wpe_pkg::acc_ctrl_type                ctrl,
   output logic signed [wpe_pkg::SAMPLE_BITS-1:0] rd_min,
   output logic signed [wpe_pkg::SAMPLE_BITS-1:0] rd_max,
   output logic [wpe_pkg::SUM_BITS-1:0]         rd_sum
);
   import wpe_pkg::*;

   logic signed [SAMPLE_BITS-1:0] min_ff [MAX_CHANNELS][NUM_LEVELS];
   logic signed [SAMPLE_BITS-1:0] max_ff [MAX_CHANNELS][NUM_LEVELS];
   logic [SUM_BITS-1:0]           sum_ff [MAX_CHANNELS][NUM_LEVELS];
   logic signed [MAG_BITS-1:0]    sample_ext;
   logic [MAG_BITS-1:0]           mag;

   assign sample_ext = MAG_BITS'(ctrl.sample);
   assign mag        = sample_ext[MAG_BITS-1] ? MAG_BITS'(-sample_ext) : sample_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            for (int l = 0; l < NUM_LEVELS; l++) begin
               min_ff[c][l] <= '0;
               max_ff[c][l] <= '0;
               sum_ff[c][l] <= '0;
            end
         end
      end else if (ctrl.upd) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (ctrl.first[l] || ctrl.sample > max_ff[ctrl.ch][l]) begin
               max_ff[ctrl.ch][l] <= ctrl.sample;
            end
            if (ctrl.first[l] || ctrl.sample < min_ff[ctrl.ch][l]) begin
               min_ff[ctrl.ch][l] <= ctrl.sample;
            end
            sum_ff[ctrl.ch][l] <= sum_ff[ctrl.ch][l] + SUM_BITS'(mag);
         end
      end else begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            if (ctrl.clear[l]) begin
               for (int c = 0; c < MAX_CHANNELS; c++) begin
                  min_ff[c][l] <= '0;
                  max_ff[c][l] <= '0;
                  sum_ff[c][l] <= '0;
               end
            end
         end
      end
   end

   assign rd_min = min_ff[ctrl.rd_ch][ctrl.rd_lv];
   assign rd_max = max_ff[ctrl.rd_ch][ctrl.rd_lv];
   assign rd_sum = sum_ff[ctrl.rd_ch][ctrl.rd_lv];

   a_no_update_during_clear: assert property (@(posedge clock) disable iff (reset)
      ctrl.upd |-> ctrl.clear == '0)
      else $error("accumulator update collides with level clear");

endmodule

### sv/waveform_peak_envelope_decimator_top.sv
// Top level: sequencer, frame and block counters, registers and record output stage.
// A sample transfer that closes no block goes through apply back to idle, and requests stall
// outside idle. Each record goes through start, the divider steps, divider done and output. A
// closing block scans before each emitting level and once more at the end; a burst holds at most
// 16 records. Synchronous active-high reset clears all stores and counters at once and loads the
// registers with 2 channels, fine block 256 and coarse block 362 frames.
module waveform_peak_envelope_decimator_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  wpe_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output wpe_pkg::rsp_type                  rsp_data,
   input  logic                              csr_write,
   input  logic [wpe_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [wpe_pkg::CSR_BITS-1:0]      csr_data
);
   import wpe_pkg::*;

   state_type             state_ff, state_in;
   req_type               item_ff, item_in;
   logic [CH_BITS-1:0]    slot_ff, slot_in;
   logic [LEN_BITS-1:0]   frames_ff [NUM_LEVELS];
   logic [LEN_BITS-1:0]   frames_in [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] mask_ff, mask_in;
   logic                  lv_ff, lv_in;
   logic [CH_BITS-1:0]    ch_ff, ch_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;
   logic [CC_BITS-1:0]    chan_count_ff;
   logic [LEN_BITS-1:0]   len_fine_ff, len_coarse_ff;

   logic                  accept;
   logic                  is_flush;
   logic [CH_BITS-1:0]    last_ch;
   logic [CH_BITS-1:0]    slot_next;
   logic                  close;
   logic [LEN_BITS-1:0]   len_eff [NUM_LEVELS];
   logic [LEN_BITS-1:0]   frames_inc [NUM_LEVELS];
   logic [NUM_LEVELS-1:0] mask_new;
   logic                  out_free;
   logic                  last_rec;
   logic                  div_start;
   logic                  div_done;
   logic [SUM_BITS-1:0]   quotient;
   logic [LEN_BITS-1:0]   cur_frames;
   acc_ctrl_type          acc_ctrl;
   logic signed [SAMPLE_BITS-1:0] rd_min, rd_max;
   logic [SUM_BITS-1:0]   rd_sum;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign is_flush  = (item_ff.op == OP_FLUSH);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_next = slot_ff + 1'b1;

   always_comb begin
      if (chan_count_ff == '0) begin
         last_ch = '0;
      end else if (chan_count_ff >= CC_BITS'(MAX_CHANNELS)) begin
         last_ch = CH_BITS'(MAX_CHANNELS - 1);
      end else begin
         last_ch = CH_BITS'(chan_count_ff - 1'b1);
      end
   end

   assign len_eff[0] = (len_fine_ff == '0) ? LEN_BITS'(1) : len_fine_ff;
   assign len_eff[1] = (len_coarse_ff == '0) ? LEN_BITS'(1) : len_coarse_ff;

   assign close = is_flush ? (slot_ff != '0) : (slot_next == '0 || slot_next > last_ch);

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         if (close && frames_ff[l] != FRAMES_MAX) begin
            frames_inc[l] = frames_ff[l] + 1'b1;
         end else begin
            frames_inc[l] = frames_ff[l];
         end
         mask_new[l] = is_flush ? (frames_inc[l] != '0) : (close && frames_inc[l] >= len_eff[l]);
      end
   end

   assign cur_frames = frames_ff[lv_ff];
   assign last_rec   = (ch_ff == last_ch) && (lv_ff || !mask_ff[1]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            state_in = (mask_new != '0) ? ST_SCAN : ST_IDLE;
         end
         ST_SCAN: begin
            state_in = (mask_ff != '0) ? ST_START : ST_IDLE;
         end
         ST_START: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) state_in = (ch_ff == last_ch) ? ST_SCAN : ST_START;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath controls and register updates
   always_comb begin
      item_in      = item_ff;
      slot_in      = slot_ff;
      frames_in    = frames_ff;
      mask_in      = mask_ff;
      lv_in        = lv_ff;
      ch_in        = ch_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      div_start    = 1'b0;
      acc_ctrl.upd    = 1'b0;
      acc_ctrl.ch     = slot_ff;
      acc_ctrl.sample = item_ff.sample;
      acc_ctrl.clear  = '0;
      acc_ctrl.rd_ch  = ch_ff;
      acc_ctrl.rd_lv  = lv_ff;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         acc_ctrl.first[l] = (frames_ff[l] == '0);
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) item_in = req_data;
         end
         ST_APPLY: begin
            acc_ctrl.upd = !is_flush;
            if (close) begin
               slot_in = '0;
            end else if (!is_flush) begin
               slot_in = slot_next;
            end
            frames_in = frames_inc;
            mask_in   = mask_new;
         end
         ST_SCAN: begin
            lv_in = !mask_ff[0];
            ch_in = '0;
         end
         ST_START: begin
            div_start = 1'b1;
         end
         ST_DIV: begin
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.level     = lv_ff;
               rsp_data_in.chan      = ch_ff;
               rsp_data_in.min_value = rd_min;
               rsp_data_in.max_value = rd_max;
               rsp_data_in.abs_mean  = (cur_frames == '0) ? '0 : quotient[SAMPLE_BITS-1:0];
               rsp_data_in.last      = last_rec;
               if (ch_ff == last_ch) begin
                  acc_ctrl.clear[lv_ff] = 1'b1;
                  frames_in[lv_ff]      = '0;
                  mask_in[lv_ff]        = 1'b0;
               end else begin
                  ch_in = ch_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         slot_ff       <= '0;
         frames_ff     <= '{default: '0};
         mask_ff       <= '0;
         lv_ff         <= 1'b0;
         ch_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
         chan_count_ff <= CHANNEL_COUNT_RESET;
         len_fine_ff   <= BLOCK_LEN_FINE_RESET;
         len_coarse_ff <= BLOCK_LEN_COARSE_RESET;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         frames_ff    <= frames_in;
         mask_ff      <= mask_in;
         lv_ff        <= lv_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               CSR_CHANNEL_COUNT:    chan_count_ff <= csr_data[CC_BITS-1:0];
               CSR_BLOCK_LEN_FINE:   len_fine_ff   <= csr_data[LEN_BITS-1:0];
               CSR_BLOCK_LEN_COARSE: len_coarse_ff <= csr_data[LEN_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   wpe_accum u_accum (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (acc_ctrl),
      .rd_min (rd_min),
      .rd_max (rd_max),
      .rd_sum (rd_sum)
   );

   wpe_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_sum),
      .divisor  (cur_frames),
      .done     (div_done),
      .quotient (quotient)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_div_level_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_OUT) |-> mask_ff[lv_ff])
      else $error("record in progress for a level that is not emitting");

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free && last_rec) |=> (mask_ff == '0 && state_ff == ST_SCAN))
      else $error("levels still pending after the final record");

   a_close_resets_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && close) |=> slot_ff == '0)
      else $error("channel slot not rewound at frame close");

endmodule

### dv/tb_waveform_peak_envelope_decimator_top.sv
// Self-checking testbench for the waveform peak envelope decimator: directed table, random phases.
`timescale 1ns / 1ps
module tb_waveform_peak_envelope_decimator_top;
   import wpe_pkg::*;

   typedef enum logic {ROW_SEND, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      req_type                 item;
      logic [CSR_IDX_BITS-1:0] index;
      logic [CSR_BITS-1:0]     value;
      int                      hand_count;
      rsp_type                 hand_first;
   } plan_row_type;

   logic                    clock     = 1'b0;
   logic                    reset     = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data  = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;
   logic                    csr_write = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_BITS-1:0]     csr_data  = '0;

   logic signed [SAMPLE_BITS-1:0] min_acc     [MAX_CHANNELS*NUM_LEVELS];
   logic signed [SAMPLE_BITS-1:0] max_acc     [MAX_CHANNELS*NUM_LEVELS];
   logic [SUM_BITS-1:0]           abs_sum_acc [MAX_CHANNELS*NUM_LEVELS];
   logic [LEN_BITS-1:0]           frame_cnt   [NUM_LEVELS];
   logic [CH_BITS-1:0]            slot_pos;
   logic [CC_BITS-1:0]            cfg_channels;
   logic [LEN_BITS-1:0]           cfg_len     [NUM_LEVELS];

   rsp_type      envelope_q [$];
   plan_row_type plan [$];

   int fail_count      = 0;
   int sender_idle_pct = 0;
   int stall_pct       = 0;
   int hold_len        = 0;
   int hold_stamp      = 0;
   int hold_seen       = 0;
   int hold_left       = 0;

   waveform_peak_envelope_decimator_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (hold_stamp != hold_seen) begin
         hold_seen <= hold_stamp;
         hold_left <= hold_len;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   function automatic void check_field(string name, logic signed [31:0] want_v,
                                       logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         $error("%s: expected %0d, got %0d", name, want_v, got_v);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (envelope_q.size() == 0) begin
            $error("record with none pending: level %0d chan %0d", rsp_data.level, rsp_data.chan);
            fail_count++;
         end else begin
            want = envelope_q.pop_front();
            check_field("level", 32'(want.level), 32'(rsp_data.level));
            check_field("chan", 32'(want.chan), 32'(rsp_data.chan));
            check_field("min_value", 32'(want.min_value), 32'(rsp_data.min_value));
            check_field("max_value", 32'(want.max_value), 32'(rsp_data.max_value));
            check_field("abs_mean", 32'(want.abs_mean), 32'(rsp_data.abs_mean));
            check_field("last", 32'(want.last), 32'(rsp_data.last));
         end
      end
   end

   function automatic int active_channels();
      if (cfg_channels == 0) return 1;
      if (cfg_channels > MAX_CHANNELS) return MAX_CHANNELS;
      return int'(cfg_channels);
   endfunction

   function automatic logic [LEN_BITS-1:0] active_len(int lv);
      return (cfg_len[lv] == '0) ? LEN_BITS'(1) : cfg_len[lv];
   endfunction

   function automatic void emit_summaries(int lv);
      rsp_type             rec;
      logic [SUM_BITS-1:0] mean;
      int                  idx;
      for (int ch = 0; ch < active_channels(); ch++) begin
         idx = ch * NUM_LEVELS + lv;
         mean = (frame_cnt[lv] != 0) ? abs_sum_acc[idx] / frame_cnt[lv] : '0;
         rec.level     = lv[0];
         rec.chan      = ch[CH_BITS-1:0];
         rec.min_value = min_acc[idx];
         rec.max_value = max_acc[idx];
         rec.abs_mean  = mean[SAMPLE_BITS-1:0];
         rec.last      = 1'b0;
         envelope_q.insert(envelope_q.size(), rec);
      end
      for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
         idx = ch * NUM_LEVELS + lv;
         min_acc[idx]     = '0;
         max_acc[idx]     = '0;
         abs_sum_acc[idx] = '0;
      end
      frame_cnt[lv] = '0;
   endfunction

   function automatic void close_frame(bit flush);
      slot_pos = '0;
      for (int lv = 0; lv < NUM_LEVELS; lv++)
         if (frame_cnt[lv] != FRAMES_MAX) frame_cnt[lv] = frame_cnt[lv] + 1'b1;
      for (int lv = 0; lv < NUM_LEVELS; lv++)
         if (frame_cnt[lv] >= active_len(lv) || (flush && frame_cnt[lv] != 0))
            emit_summaries(lv);
   endfunction

   function automatic int track_envelope(req_type item);
      int      before_n;
      int      mag;
      int      idx;
      before_n = envelope_q.size();
      if (item.op == OP_FLUSH) begin
         if (slot_pos != 0) begin
            close_frame(1'b1);
         end else begin
            for (int lv = 0; lv < NUM_LEVELS; lv++)
               if (frame_cnt[lv] != 0) emit_summaries(lv);
         end
      end else begin
         mag = int'(item.sample);
         if (mag < 0) mag = -mag;
         for (int lv = 0; lv < NUM_LEVELS; lv++) begin
            idx = slot_pos * NUM_LEVELS + lv;
            if (frame_cnt[lv] == 0 || item.sample > max_acc[idx]) max_acc[idx] = item.sample;
            if (frame_cnt[lv] == 0 || item.sample < min_acc[idx]) min_acc[idx] = item.sample;
            abs_sum_acc[idx] = abs_sum_acc[idx] + mag;
         end
         slot_pos = slot_pos + 1'b1;
         if (slot_pos == 0 || slot_pos >= active_channels()) close_frame(1'b0);
      end
      if (envelope_q.size() > before_n) envelope_q[envelope_q.size() - 1].last = 1'b1;
      return envelope_q.size() - before_n;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int      pick;
      pick = $urandom_range(0, 99);
      it.op = (pick < 6) ? OP_FLUSH : OP_SAMPLE;
      it.sample = SAMPLE_BITS'($urandom());
      if (pick >= 6 && pick < 22) begin
         case ($urandom_range(0, 3))
            0: it.sample = 16'h7FFF;
            1: it.sample = 16'h8000;
            2: it.sample = 16'h0000;
            default: it.sample = 16'hFFFF;
         endcase
      end
      return it;
   endfunction

   function automatic plan_row_type item_row(logic op, logic [SAMPLE_BITS-1:0] value,
                                             int hand_count = -1, rsp_type hand = '0);
      plan_row_type row;
      row.kind        = ROW_SEND;
      row.item.op     = op;
      row.item.sample = value;
      row.index       = '0;
      row.value       = '0;
      row.hand_count  = hand_count;
      row.hand_first  = hand;
      return row;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_IDX_BITS-1:0] idx, int value);
      plan_row_type row;
      row = item_row(OP_SAMPLE, '0);
      row.kind  = ROW_WRITE;
      row.index = idx;
      row.value = CSR_BITS'(value);
      return row;
   endfunction

   function automatic void add_row(plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   function automatic rsp_type hand_rec(logic [SAMPLE_BITS-1:0] lo, logic [SAMPLE_BITS-1:0] hi,
                                        logic [SAMPLE_BITS-1:0] mean);
      rsp_type rec;
      rec           = '0;
      rec.min_value = lo;
      rec.max_value = hi;
      rec.abs_mean  = mean;
      return rec;
   endfunction

   task automatic send_item(input req_type item, output int produced);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      produced = track_envelope(item);
      gap = 0;
      while ($urandom_range(0, 99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (envelope_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_BITS-1:0] idx, input logic [CSR_BITS-1:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         CSR_CHANNEL_COUNT:    cfg_channels = value[CC_BITS-1:0];
         CSR_BLOCK_LEN_FINE:   cfg_len[0]   = value[LEN_BITS-1:0];
         CSR_BLOCK_LEN_COARSE: cfg_len[1]   = value[LEN_BITS-1:0];
         default: ;
      endcase
   endtask

   task automatic run_phase(int channels, int len_fine, int len_coarse, int idle_pct,
                            int stall_v, int items, int hold, bit mid_pause);
      int produced;
      wait_idle();
      write_csr(CSR_CHANNEL_COUNT, CSR_BITS'(channels));
      write_csr(CSR_BLOCK_LEN_FINE, CSR_BITS'(len_fine));
      write_csr(CSR_BLOCK_LEN_COARSE, CSR_BITS'(len_coarse));
      csr_write <= 1'b0;
      sender_idle_pct = idle_pct;
      stall_pct <= stall_v;
      if (hold > 0) begin
         hold_len   <= hold;
         hold_stamp <= hold_stamp + 1;
      end
      for (int i = 0; i < items; i++) begin
         if (mid_pause && i == items / 2) wait_idle();
         send_item(random_item(), produced);
      end
   endtask

   initial begin
      #4_000_000;
      $display("** waveform_peak_envelope_decimator_top: FAILED **");
      $finish;
   end

   initial begin
      plan_row_type row;
      int           produced;
      cfg_channels = CHANNEL_COUNT_RESET;
      cfg_len[0]   = BLOCK_LEN_FINE_RESET;
      cfg_len[1]   = BLOCK_LEN_COARSE_RESET;
      slot_pos     = '0;
      for (int i = 0; i < MAX_CHANNELS * NUM_LEVELS; i++) begin
         min_acc[i]     = '0;
         max_acc[i]     = '0;
         abs_sum_acc[i] = '0;
      end
      for (int lv = 0; lv < NUM_LEVELS; lv++) frame_cnt[lv] = '0;

      add_row(item_row(OP_FLUSH, 16'h0000, 0));
      add_row(csr_row(CSR_CHANNEL_COUNT, 1));
      add_row(csr_row(CSR_BLOCK_LEN_FINE, 1));
      add_row(csr_row(CSR_BLOCK_LEN_COARSE, 0));
      add_row(item_row(OP_SAMPLE, 16'h7FFF, 2, hand_rec(16'h7FFF, 16'h7FFF, 16'h7FFF)));
      add_row(item_row(OP_SAMPLE, 16'h8000, 2, hand_rec(16'h8000, 16'h8000, 16'h8000)));
      add_row(item_row(OP_SAMPLE, 16'h0000, 2, hand_rec(16'h0000, 16'h0000, 16'h0000)));
      add_row(item_row(OP_SAMPLE, 16'hFFFF, 2, hand_rec(16'hFFFF, 16'hFFFF, 16'h0001)));
      add_row(csr_row(CSR_CHANNEL_COUNT, 0));
      add_row(item_row(OP_SAMPLE, 16'h5555, 2, hand_rec(16'h5555, 16'h5555, 16'h5555)));
      add_row(csr_row(CSR_CHANNEL_COUNT, 15));
      add_row(csr_row(CSR_BLOCK_LEN_FINE, 3));
      add_row(csr_row(CSR_BLOCK_LEN_COARSE, 65536));
      add_row(item_row(OP_SAMPLE, 16'h7FFF));
      add_row(item_row(OP_SAMPLE, 16'h8000));
      add_row(item_row(OP_SAMPLE, 16'h0001));
      add_row(item_row(OP_SAMPLE, 16'hFFFF));
      add_row(item_row(OP_SAMPLE, 16'h2AAA));
      add_row(item_row(OP_SAMPLE, 16'hD555));
      add_row(item_row(OP_SAMPLE, 16'h0000));
      add_row(item_row(OP_SAMPLE, 16'h1234));
      add_row(item_row(OP_FLUSH, 16'h0000));
      add_row(csr_row(CSR_CHANNEL_COUNT, 2));
      add_row(csr_row(CSR_BLOCK_LEN_FINE, 4));
      add_row(csr_row(CSR_BLOCK_LEN_COARSE, 2));
      add_row(item_row(OP_SAMPLE, 16'h0100));
      add_row(item_row(OP_SAMPLE, 16'hFF00));
      add_row(item_row(OP_SAMPLE, 16'h7FFF));
      add_row(item_row(OP_SAMPLE, 16'h8001));
      add_row(item_row(OP_SAMPLE, 16'h0010));
      add_row(item_row(OP_SAMPLE, 16'hFFF0));
      add_row(item_row(OP_SAMPLE, 16'h4000));
      add_row(csr_row(CSR_BLOCK_LEN_FINE, 1));
      add_row(csr_row(CSR_CHANNEL_COUNT, 1));
      add_row(item_row(OP_SAMPLE, 16'hC000));
      add_row(csr_row(CSR_CHANNEL_COUNT, 3));
      add_row(item_row(OP_SAMPLE, 16'h0AAA));
      add_row(item_row(OP_FLUSH, 16'hFFFF));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         row = plan[r];
         if (row.kind == ROW_WRITE) begin
            wait_idle();
            write_csr(row.index, row.value);
            csr_write <= 1'b0;
         end else begin
            send_item(row.item, produced);
            if (row.hand_count >= 0) begin
               if (produced != row.hand_count) begin
                  $error("row %0d record count: expected %0d, got %0d", r, row.hand_count,
                         produced);
                  fail_count++;
               end else if (produced > 0 &&
                            envelope_q[envelope_q.size() - produced] != row.hand_first) begin
                  $error("row %0d first record: expected %h, got %h", r, row.hand_first,
                         envelope_q[envelope_q.size() - produced]);
                  fail_count++;
               end
            end
         end
      end

      run_phase(8, 1, 2, 0, 0, 12, 0, 1'b0);
      run_phase(3, 2, 65535, 70, 0, 14, 0, 1'b1);
      run_phase(1, 65536, 1, 0, 70, 12, 0, 1'b0);
      run_phase(5, 7, 3, 13, 13, 14, 0, 1'b0);
      run_phase(8, 1, 1, 0, 0, 16, 400, 1'b0);
      run_phase($urandom_range(0, 15), $urandom_range(0, 6), $urandom_range(0, 6), 13, 70, 12,
                0, 1'b0);

      wait_idle();
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("** waveform_peak_envelope_decimator_top: PASSED **");
      else
         $display("** waveform_peak_envelope_decimator_top: FAILED **");
      $finish;
   end

endmodule
